// ----- rtl/core/disk_image_cluster_read_splitter_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the cluster read splitter
// Clocked implication checks, disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef DISK_IMAGE_CLUSTER_READ_SPLITTER_TOP_ASSERT_SVH
`define DISK_IMAGE_CLUSTER_READ_SPLITTER_TOP_ASSERT_SVH

// Same-cycle implication.
`define DICRS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DICRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/dicrs_pkg.sv -----
// ----------------------------------------------------------------------------
// dicrs_pkg
// Shared constants, codes and types of the cluster read splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package dicrs_pkg;

    localparam int TABLE_DEPTH     = 4096;
    localparam int TABLE_AW        = 12;
    localparam int MAX_REQ_BYTES   = 16384;
    localparam int SECTOR_SHIFT    = 9;

    localparam int POS_W           = 48;
    localparam int LEN_W           = 15;
    localparam int ADDR_W          = 57;
    localparam int ENTRY_W         = 32;
    localparam int CSEC_W          = 16;
    localparam int TSEC_W          = 39;
    localparam int TENT_W          = 13;
    localparam int CBYTE_W         = CSEC_W + SECTOR_SHIFT;
    localparam int PROD_W          = ENTRY_W + CSEC_W;

    localparam int CFG_AW          = 5;
    localparam int CFG_DW          = 64;

    // Input item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Register indexes (paddr[4:3])
    typedef enum logic [1:0] {
        CFG_CLUSTER_SECTORS = 2'd0,
        CFG_TOTAL_SECTORS   = 2'd1,
        CFG_EXTENDED_MODE   = 2'd2,
        CFG_TABLE_ENTRIES   = 2'd3
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_READ = 5'b00100,
        S_CALC = 5'b01000,
        S_ADDR = 5'b10000
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/core/dicrs_ifs.sv -----
// ----------------------------------------------------------------------------
// dicrs_ifs
// Valid/ready channels: request items in, chunk results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface dicrs_req_if import dicrs_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 kind;
    logic [TABLE_AW-1:0]  table_index;
    logic [ENTRY_W-1:0]   table_value;
    logic [POS_W-1:0]     request_position;
    logic [LEN_W-1:0]     request_length;

    modport source (output valid, kind, table_index, table_value,
                    request_position, request_length, input ready);
    modport sink   (input valid, kind, table_index, table_value,
                    request_position, request_length, output ready);
endinterface

interface dicrs_rsp_if import dicrs_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [ADDR_W-1:0]    phys_address;
    logic [LEN_W-1:0]     chunk_length;
    logic                 zero_fill;
    logic                 rejected;
    logic                 last_chunk;

    modport source (output valid, phys_address, chunk_length, zero_fill,
                    rejected, last_chunk, input ready);
    modport sink   (input valid, phys_address, chunk_length, zero_fill,
                    rejected, last_chunk, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/disk_image_cluster_read_splitter_top.sv -----
// ----------------------------------------------------------------------------
// disk_image_cluster_read_splitter_top
// Splits virtual-disk reads into per-cluster chunks via an allocation table.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries load items (kind 0: write one allocation table entry) and
//   read requests (kind 1: byte position and length). o_rsp returns one chunk
//   per cluster touched, with the physical address, length, zero-fill mark and
//   last_chunk on the final one. An empty request, or one starting at or past
//   the disk end, returns a single rejected chunk of length 0.
//   A read runs a bit-serial restoring divider (byte position over cluster
//   size), then for each chunk a table RAM read, a multiply and an address
//   add, for up to 33 chunks. Results sit in an output register; the
//   sequencer waits only when that register is full and not being drained,
//   and the next item is taken no earlier than the cycle in which the final
//   chunk drains. Configuration goes over the APB-style port, 64-bit
//   registers at 8-byte steps; the user must write them only while the
//   block is idle, which the block itself does not enforce.
//   Reset (synchronous, active low) restores the register defaults and the
//   idle state; the table contents are undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module disk_image_cluster_read_splitter_top import dicrs_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    dicrs_req_if.sink              i_req,
    dicrs_rsp_if.source            o_rsp,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [CFG_DW-1:0] pwdata,
    output logic      [CFG_DW-1:0] prdata,
    output logic                   pready
);

    localparam int QUO_W = POS_W - SECTOR_SHIFT;
    localparam logic [TENT_W-1:0] DEPTH_LIM = TENT_W'(TABLE_DEPTH);
    localparam logic [LEN_W-1:0]  LEN_LIM   = LEN_W'(MAX_REQ_BYTES);
    localparam logic [5:0]        DIV_LAST  = 6'(QUO_W - 1);

    // configuration
    logic [CSEC_W-1:0] r_cluster_sectors;
    logic [TSEC_W-1:0] r_total_sectors;
    logic              r_extended_mode;
    logic [TENT_W-1:0] r_table_entries;

    // sequencer and datapath
    t_state             r_state;
    logic [QUO_W-1:0]   r_quo;
    logic [CSEC_W-1:0]  r_rem;
    logic [5:0]         r_cnt;
    logic [SECTOR_SHIFT-1:0] r_pos_lo;
    logic [LEN_W-1:0]   r_want;
    logic [LEN_W-1:0]   r_done;
    logic [CBYTE_W-1:0] r_off;
    logic [LEN_W-1:0]   r_n;
    logic               r_in_range;
    logic [ENTRY_W-1:0] r_rd_data;
    logic [PROD_W-1:0]  r_prod;
    logic               r_zf;

    // output register
    logic               r_out_valid;
    logic [ADDR_W-1:0]  r_out_addr;
    logic [LEN_W-1:0]   r_out_len;
    logic               r_out_zf;
    logic               r_out_rej;
    logic               r_out_last;

    logic [ENTRY_W-1:0] r_table [TABLE_DEPTH];

    logic               cfg_we;
    logic [CSEC_W-1:0]  cs_eff;
    logic [TENT_W-1:0]  entries_eff;
    logic [CBYTE_W-1:0] cluster_bytes;
    logic               out_free;
    logic               in_fire;
    logic [LEN_W-1:0]   len_sat;
    logic               req_reject;
    logic [POS_W-1:0]   room;
    logic [LEN_W-1:0]   want;
    logic [CSEC_W:0]    div_trial;
    logic               div_ge;
    logic [CSEC_W:0]    div_sub;
    logic [CSEC_W-1:0]  rem_nx;
    logic [LEN_W-1:0]   left;
    logic [CBYTE_W-1:0] span;
    logic [LEN_W-1:0]   n_len;
    logic [PROD_W-1:0]  mul_p;
    logic [LEN_W-1:0]   done_nx;
    logic               is_last;
    logic               load_chunk;
    logic               load_rej;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cluster_sectors <= CSEC_W'(2048);
            r_total_sectors   <= TSEC_W'(1);
            r_extended_mode   <= 1'b0;
            r_table_entries   <= TENT_W'(1);
        end else if (cfg_we) begin
            unique case (t_cfg_idx'(paddr[4:3]))
                CFG_CLUSTER_SECTORS: r_cluster_sectors <= pwdata[CSEC_W-1:0];
                CFG_TOTAL_SECTORS:   r_total_sectors   <= pwdata[TSEC_W-1:0];
                CFG_EXTENDED_MODE:   r_extended_mode   <= pwdata[0];
                CFG_TABLE_ENTRIES:   r_table_entries   <= pwdata[TENT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (t_cfg_idx'(paddr[4:3]))
            CFG_CLUSTER_SECTORS: prdata = CFG_DW'(r_cluster_sectors);
            CFG_TOTAL_SECTORS:   prdata = CFG_DW'(r_total_sectors);
            CFG_EXTENDED_MODE:   prdata = CFG_DW'(r_extended_mode);
            CFG_TABLE_ENTRIES:   prdata = CFG_DW'(r_table_entries);
            default:             prdata = '0;
        endcase
    end

    // ---------------- derived settings ----------------
    assign cs_eff        = (r_cluster_sectors == '0) ? CSEC_W'(1) : r_cluster_sectors;
    assign entries_eff   = (r_table_entries > DEPTH_LIM) ? DEPTH_LIM : r_table_entries;
    assign cluster_bytes = {cs_eff, {SECTOR_SHIFT{1'b0}}};

    // ---------------- request intake ----------------
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE) && out_free;
    assign in_fire     = i_req.valid && i_req.ready;

    assign len_sat    = (i_req.request_length > LEN_LIM) ? LEN_LIM : i_req.request_length;
    // pos >= sectors*512 is the same as pos/512 >= sectors
    assign req_reject = (len_sat == '0) ||
                        (i_req.request_position[POS_W-1:SECTOR_SHIFT] >= r_total_sectors);
    assign room       = {r_total_sectors, {SECTOR_SHIFT{1'b0}}} - i_req.request_position;
    assign want       = (room > POS_W'(len_sat)) ? len_sat : room[LEN_W-1:0];

    // ---------------- restoring divider step ----------------
    assign div_trial = {r_rem, r_quo[QUO_W-1]};
    assign div_ge    = div_trial >= {1'b0, cs_eff};
    assign div_sub   = div_trial - {1'b0, cs_eff};
    assign rem_nx    = div_ge ? div_sub[CSEC_W-1:0] : div_trial[CSEC_W-1:0];

    // ---------------- chunk sizing and address ----------------
    assign left    = r_want - r_done;
    assign span    = cluster_bytes - r_off;
    assign n_len   = (span > CBYTE_W'(left)) ? left : span[LEN_W-1:0];
    assign mul_p   = r_rd_data * cs_eff;
    assign done_nx = r_done + r_n;
    assign is_last = (done_nx == r_want);

    assign load_chunk = (r_state == S_ADDR) && out_free;
    assign load_rej   = in_fire && (i_req.kind == KIND_READ) && req_reject;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire && (i_req.kind == KIND_READ) && !req_reject) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_cnt == '0) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: r_state <= S_CALC;
                S_CALC: r_state <= S_ADDR;
                S_ADDR: begin
                    if (out_free) begin
                        r_state <= is_last ? S_IDLE : S_READ;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_quo    <= i_req.request_position[POS_W-1:SECTOR_SHIFT];
                r_rem    <= '0;
                r_cnt    <= DIV_LAST;
                r_pos_lo <= i_req.request_position[SECTOR_SHIFT-1:0];
                r_want   <= want;
                r_done   <= '0;
            end
            S_DIV: begin
                r_quo <= {r_quo[QUO_W-2:0], div_ge};
                r_rem <= rem_nx;
                r_cnt <= r_cnt - 6'd1;
                r_off <= {rem_nx, r_pos_lo};
            end
            S_READ: begin
                r_n        <= n_len;
                r_in_range <= r_quo < QUO_W'(entries_eff);
            end
            S_CALC: begin
                r_zf   <= !r_in_range || (r_rd_data == '0);
                r_prod <= r_extended_mode ? mul_p : PROD_W'(r_rd_data);
            end
            S_ADDR: begin
                if (out_free) begin
                    r_done <= done_nx;
                    r_quo  <= r_quo + QUO_W'(1);
                    r_off  <= '0;
                end
            end
            default: ;
        endcase
    end

    // allocation table
    always_ff @(posedge i_clk) begin
        if (in_fire && (i_req.kind == KIND_LOAD)) begin
            r_table[i_req.table_index] <= i_req.table_value;
        end
        if (r_state == S_READ) begin
            r_rd_data <= r_table[r_quo[TABLE_AW-1:0]];
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_chunk || load_rej) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_rej) begin
            r_out_addr <= '0;
            r_out_len  <= '0;
            r_out_zf   <= 1'b0;
            r_out_rej  <= 1'b1;
            r_out_last <= 1'b1;
        end else if (load_chunk) begin
            r_out_addr <= r_zf ? '0
                               : ({r_prod, {SECTOR_SHIFT{1'b0}}} + ADDR_W'(r_off));
            r_out_len  <= r_n;
            r_out_zf   <= r_zf;
            r_out_rej  <= 1'b0;
            r_out_last <= is_last;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.phys_address = r_out_addr;
    assign o_rsp.chunk_length = r_out_len;
    assign o_rsp.zero_fill    = r_out_zf;
    assign o_rsp.rejected     = r_out_rej;
    assign o_rsp.last_chunk   = r_out_last;

    // ---------------- assertions ----------------
`include "disk_image_cluster_read_splitter_top_assert.svh"

    `DICRS_ASSERT_NEXT(a_div_done, i_clk, i_rst_n, (r_state == S_DIV) && (r_cnt == '0), r_state == S_READ, "divider did not hand over to table read")
    `DICRS_ASSERT_NOW(a_rej_shape, i_clk, i_rst_n, r_out_valid && r_out_rej, r_out_last && (r_out_len == '0) && !r_out_zf, "rejected result malformed")
    `DICRS_ASSERT_NOW(a_zf_addr, i_clk, i_rst_n, r_out_valid && r_out_zf, r_out_addr == '0, "zero-fill chunk carries an address")
    `DICRS_ASSERT_NOW(a_chunk_len, i_clk, i_rst_n, r_out_valid && !r_out_rej, r_out_len != '0, "empty chunk emitted")

endmodule

`default_nettype wire
